// ===== rtl/voxel_cube_rotation_scatter_macros.svh =====
// Assertion macros used by the checker file of the voxel rotation block
`ifndef VOXEL_CUBE_ROTATION_SCATTER_MACROS_SVH
`define VOXEL_CUBE_ROTATION_SCATTER_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define VCR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("voxel rotation check failed");

// Clocked assertion that stays armed through reset
`define VCR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("voxel rotation reset check failed");

`endif

// ===== rtl/vcr_pkg.sv =====
// Shared types, constants and orientation decode for the voxel rotation block
package vcr_pkg;

    localparam int VALUE_W    = 32;
    localparam int DEST_W     = 24;
    localparam int CFG_W      = 7;
    localparam int ROT_W      = 5;
    localparam int CFG_ADDR_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_CUBE_SIDE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION      = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] CUBE_SIDE_RST     = 7'd32;
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = 7'd1;
    localparam logic [ROT_W-1:0] ROTATION_RST      = 5'd0;

    localparam int NUM_FACES = 6;
    localparam int NUM_TURNS = 4;

    // Face choices (rotation mod 6)
    localparam logic [2:0] FACE_IDENT   = 3'd0;
    localparam logic [2:0] FACE_J_TO_I  = 3'd1;
    localparam logic [2:0] FACE_FLIP_IJ = 3'd2;
    localparam logic [2:0] FACE_MJ_TO_I = 3'd3;
    localparam logic [2:0] FACE_K_TO_I  = 3'd4;
    localparam logic [2:0] FACE_MK_TO_I = 3'd5;

    // Quarter turns about the i axis (rotation div 6, mod 4)
    localparam logic [1:0] TURN_0   = 2'd0;
    localparam logic [1:0] TURN_90  = 2'd1;
    localparam logic [1:0] TURN_180 = 2'd2;
    localparam logic [1:0] TURN_270 = 2'd3;

    typedef struct packed {
        logic [2:0] face;
        logic [1:0] turn;
    } t_orient;

    // Split a rotation code into face and turn by a compare ladder
    function automatic t_orient decode_orient(input logic [ROT_W-1:0] rot);
        t_orient    o;
        logic [2:0] q;
        logic [ROT_W-1:0] rem;
        if (rot >= ROT_W'(5 * NUM_FACES))      q = 3'd5;
        else if (rot >= ROT_W'(4 * NUM_FACES)) q = 3'd4;
        else if (rot >= ROT_W'(3 * NUM_FACES)) q = 3'd3;
        else if (rot >= ROT_W'(2 * NUM_FACES)) q = 3'd2;
        else if (rot >= ROT_W'(NUM_FACES))     q = 3'd1;
        else                                   q = 3'd0;
        rem = rot - ROT_W'(q) * ROT_W'(NUM_FACES);
        o.face = rem[2:0];
        o.turn = q[1:0];
        return o;
    endfunction

endpackage

// ===== rtl/vcr_front.sv =====
// Front part: configuration registers, raster counters and orientation of coordinates
module vcr_front #(
    parameter int MAX_SIDE     = 64,
    parameter int MAX_CHANNELS = 64,
    localparam int PW    = $clog2(MAX_SIDE),
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int SW    = $clog2(MAX_SIDE + 1),
    localparam int CRD_W = PW + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vcr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [vcr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_accept,
    output logic signed [CRD_W-1:0]         o_a,
    output logic signed [CRD_W-1:0]         o_b,
    output logic signed [CRD_W-1:0]         o_c,
    output logic [CW-1:0]                   o_chan,
    output logic [SW-1:0]                   o_side,
    output logic                            o_done
);
    import vcr_pkg::*;

    logic [CFG_W-1:0] r_cube_side;
    logic [CFG_W-1:0] r_channel_count;
    logic [ROT_W-1:0] r_rotation_index;

    logic [PW-1:0] r_pos_i, r_pos_j, r_pos_k;
    logic [CW-1:0] r_chan;
    logic [PW-1:0] n_pos_i, n_pos_j, n_pos_k;
    logic [CW-1:0] n_chan;

    logic [PW-1:0] side_m1;
    logic [CW-1:0] chan_m1;
    logic          last_i, last_j, last_k, last_c;
    t_orient       orient;

    logic signed [CRD_W-1:0] ci, cj, ck, cm;
    logic signed [CRD_W-1:0] fa, fb, fc, tb, tc;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cube_side      <= CUBE_SIDE_RST;
            r_channel_count  <= CHANNEL_COUNT_RST;
            r_rotation_index <= ROTATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CUBE_SIDE:     r_cube_side      <= i_cfg_data;
                REG_CHANNEL_COUNT: r_channel_count  <= i_cfg_data;
                REG_ROTATION:      r_rotation_index <= i_cfg_data[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp side and channel count, keep the last position of each
    always_comb begin
        if (r_cube_side == '0)
            side_m1 = '0;
        else if (32'(r_cube_side) > MAX_SIDE)
            side_m1 = PW'(MAX_SIDE - 1);
        else
            side_m1 = PW'(r_cube_side - 7'd1);

        if (r_channel_count == '0)
            chan_m1 = '0;
        else if (32'(r_channel_count) > MAX_CHANNELS)
            chan_m1 = CW'(MAX_CHANNELS - 1);
        else
            chan_m1 = CW'(r_channel_count - 7'd1);
    end

    assign last_k = r_pos_k >= side_m1;
    assign last_j = r_pos_j >= side_m1;
    assign last_i = r_pos_i >= side_m1;
    assign last_c = r_chan >= chan_m1;

    // Advance the raster counters, k fastest
    always_comb begin
        n_pos_k = r_pos_k;
        n_pos_j = r_pos_j;
        n_pos_i = r_pos_i;
        n_chan  = r_chan;
        if (!last_k) begin
            n_pos_k = r_pos_k + PW'(1);
        end else begin
            n_pos_k = '0;
            if (!last_j) begin
                n_pos_j = r_pos_j + PW'(1);
            end else begin
                n_pos_j = '0;
                if (!last_i) begin
                    n_pos_i = r_pos_i + PW'(1);
                end else begin
                    n_pos_i = '0;
                    n_chan  = last_c ? '0 : r_chan + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_i <= '0;
            r_pos_j <= '0;
            r_pos_k <= '0;
            r_chan  <= '0;
        end else if (i_accept) begin
            r_pos_i <= n_pos_i;
            r_pos_j <= n_pos_j;
            r_pos_k <= n_pos_k;
            r_chan  <= n_chan;
        end
    end

    // Map position through face choice, then quarter turn
    assign orient = decode_orient(r_rotation_index);
    assign ci = $signed({1'b0, r_pos_i});
    assign cj = $signed({1'b0, r_pos_j});
    assign ck = $signed({1'b0, r_pos_k});
    assign cm = $signed({1'b0, side_m1});

    always_comb begin
        fa = ci;
        fb = cj;
        fc = ck;
        case (orient.face)
            FACE_IDENT:   begin fa = ci;      fb = cj;      fc = ck;      end
            FACE_J_TO_I:  begin fa = cj;      fb = cm - ci; fc = ck;      end
            FACE_FLIP_IJ: begin fa = cm - ci; fb = cm - cj; fc = ck;      end
            FACE_MJ_TO_I: begin fa = cm - cj; fb = ci;      fc = ck;      end
            FACE_K_TO_I:  begin fa = ck;      fb = cj;      fc = cm - ci; end
            FACE_MK_TO_I: begin fa = cm - ck; fb = cj;      fc = ci;      end
            default: ;
        endcase

        tb = fb;
        tc = fc;
        case (orient.turn)
            TURN_0:   begin tb = fb;      tc = fc;      end
            TURN_90:  begin tb = fc;      tc = cm - fb; end
            TURN_180: begin tb = cm - fb; tc = cm - fc; end
            TURN_270: begin tb = cm - fc; tc = fb;      end
            default: ;
        endcase
    end

    assign o_a    = fa;
    assign o_b    = tb;
    assign o_c    = tc;
    assign o_chan = r_chan;
    assign o_side = SW'(side_m1) + SW'(1);
    assign o_done = last_k && last_j && last_i && last_c;

endmodule

// ===== rtl/vcr_queue.sv =====
// Short register queue between the front and back parts
module vcr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != NW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store pushed request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + AW'(1);
            if (do_push && !do_pop)      r_count <= r_count + NW'(1);
            else if (do_pop && !do_push) r_count <= r_count - NW'(1);
        end
    end

endmodule

// ===== rtl/vcr_back.sv =====
// Back part: three multiply-add stages that form the destination index
module vcr_back #(
    parameter int MAX_SIDE     = 64,
    parameter int MAX_CHANNELS = 64,
    localparam int PW    = $clog2(MAX_SIDE),
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int SW    = $clog2(MAX_SIDE + 1),
    localparam int CRD_W = PW + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  logic [vcr_pkg::VALUE_W-1:0]     i_value,
    input  logic signed [CRD_W-1:0]         i_a,
    input  logic signed [CRD_W-1:0]         i_b,
    input  logic signed [CRD_W-1:0]         i_c,
    input  logic [CW-1:0]                   i_chan,
    input  logic [SW-1:0]                   i_side,
    input  logic                            i_done,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [vcr_pkg::VALUE_W-1:0]     o_value,
    output logic [vcr_pkg::DEST_W-1:0]      o_dest,
    output logic                            o_done
);
    import vcr_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic [VALUE_W-1:0]      r1_value, r2_value, r3_value;
    logic [DEST_W-1:0]       r1_x, r2_x, r3_x;
    logic signed [CRD_W-1:0] r1_b, r1_c, r2_c;
    logic [SW-1:0]           r1_side, r2_side;
    logic                    r1_done, r2_done, r3_done;

    logic [DEST_W-1:0] x1, x2, x3;

    // Advance all stages when the output slot frees up
    assign en    = !r_v3 || i_ready;
    assign o_pop = en && i_valid;

    // Horner form: ((chan*n + a)*n + b)*n + c, modulo 2^24
    assign x1 = DEST_W'(i_chan) * DEST_W'(i_side) + DEST_W'(i_a);
    assign x2 = r1_x * DEST_W'(r1_side) + DEST_W'(r1_b);
    assign x3 = r2_x * DEST_W'(r2_side) + DEST_W'(r2_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Carry payload down the stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_value <= i_value;
            r1_x     <= x1;
            r1_b     <= i_b;
            r1_c     <= i_c;
            r1_side  <= i_side;
            r1_done  <= i_done;

            r2_value <= r1_value;
            r2_x     <= x2;
            r2_c     <= r1_c;
            r2_side  <= r1_side;
            r2_done  <= r1_done;

            r3_value <= r2_value;
            r3_x     <= x3;
            r3_done  <= r2_done;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r3_value;
    assign o_dest  = r3_x;
    assign o_done  = r3_done;

endmodule

// ===== rtl/voxel_cube_rotation_scatter.sv =====
// Top level of the voxel cube rotation scatter block
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  input     i_in_valid/o_in_ready  i_voxel_value
//  output    o_out_valid/i_out_ready o_voxel_value_out, o_dest_index, o_example_done
//  config    i_cfg_we               i_cfg_addr, i_cfg_data
//
// One voxel per cycle sustained while the output is ready; each result is registered
// through a queue slot, then three multiply-add stages (the front is combinational).
// Synchronous active-low reset clears counters, queue and stage valids and loads
// the register defaults (side 32, one channel, identity orientation).
// A stalled output holds the back stages; the four-entry queue keeps the input
// open until it fills.
module voxel_cube_rotation_scatter #(
    parameter int MAX_SIDE     = 64,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vcr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [vcr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [vcr_pkg::VALUE_W-1:0]     i_voxel_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [vcr_pkg::VALUE_W-1:0]     o_voxel_value_out,
    output logic [vcr_pkg::DEST_W-1:0]      o_dest_index,
    output logic                            o_example_done
);
    import vcr_pkg::*;

    localparam int PW    = $clog2(MAX_SIDE);
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CRD_W = PW + 1;
    localparam int ENT_W = VALUE_W + 3 * CRD_W + CW + SW + 1;

    logic                    accept;
    logic signed [CRD_W-1:0] f_a, f_b, f_c, q_a, q_b, q_c;
    logic [CW-1:0]           f_chan, q_chan;
    logic [SW-1:0]           f_side, q_side;
    logic                    f_done, q_done;
    logic [VALUE_W-1:0]      q_value;
    logic [ENT_W-1:0]        push_data, pop_data;
    logic                    q_valid, q_pop;

    assign accept = i_in_valid && o_in_ready;

    vcr_front #(
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_a        (f_a),
        .o_b        (f_b),
        .o_c        (f_c),
        .o_chan     (f_chan),
        .o_side     (f_side),
        .o_done     (f_done)
    );

    // Pack one request for the queue
    assign push_data = {i_voxel_value, f_a, f_b, f_c, f_chan, f_side, f_done};

    vcr_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (push_data),
        .o_ready (o_in_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    assign {q_value, q_a, q_b, q_c, q_chan, q_side, q_done} = pop_data;

    vcr_back #(
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_value (q_value),
        .i_a     (q_a),
        .i_b     (q_b),
        .i_c     (q_c),
        .i_chan  (q_chan),
        .i_side  (q_side),
        .i_done  (q_done),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (o_voxel_value_out),
        .o_dest  (o_dest_index),
        .o_done  (o_example_done)
    );

endmodule

// ===== rtl/vcr_checker.sv =====
// Port-level checks of the voxel rotation block and their binding
`include "voxel_cube_rotation_scatter_macros.svh"

module vcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [vcr_pkg::VALUE_W-1:0] o_voxel_value_out,
    input logic [vcr_pkg::DEST_W-1:0]  o_dest_index,
    input logic                        o_example_done
);
    // A stalled result keeps its value
    `VCR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_voxel_value_out) && $stable(o_dest_index) && $stable(o_example_done))

    // Reset empties the result stage
    `VCR_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

    // The queue fills only behind a stalled output
    `VCR_ASSERT(a_full_on_stall, i_clk, i_rst_n, $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready && i_in_valid))

endmodule

bind voxel_cube_rotation_scatter vcr_checker u_vcr_checker (.*);

// ===== tb/sv/voxel_cube_rotation_scatter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the voxel cube rotation scatter block
module voxel_cube_rotation_scatter_test;
    import vcr_pkg::*;

    localparam int SIDE_LIMIT    = 64;
    localparam int CHANNEL_LIMIT = 64;
    localparam int PIPE_LATENCY  = 4;
    localparam int MAX_PRINTED   = 20;
    localparam int RANDOM_ITEMS  = 480;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [DEST_W-1:0]  dest;
        logic               done;
    } t_scatter;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = REG_CUBE_SIDE;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [VALUE_W-1:0]    i_voxel_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [VALUE_W-1:0]    o_voxel_value_out;
    logic [DEST_W-1:0]     o_dest_index;
    logic                  o_example_done;

    // Register copies and raster position of the scatter predictor
    logic [CFG_W-1:0] model_side     = CUBE_SIDE_RST;
    logic [CFG_W-1:0] model_channels = CHANNEL_COUNT_RST;
    logic [ROT_W-1:0] model_rotation = ROTATION_RST;
    int unsigned      walk_i = 0, walk_j = 0, walk_k = 0, walk_chan = 0;

    t_scatter    pending_scatter[$];
    int unsigned error_count    = 0;
    int unsigned voxels_sent    = 0;
    int unsigned examples_seen  = 0;
    int unsigned config_writes  = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    voxel_cube_rotation_scatter #(
        .MAX_SIDE    (SIDE_LIMIT),
        .MAX_CHANNELS(CHANNEL_LIMIT)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_voxel_value    (i_voxel_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_voxel_value_out(o_voxel_value_out),
        .o_dest_index     (o_dest_index),
        .o_example_done   (o_example_done)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a size register into 1..limit
    function automatic int unsigned effective_limit(input logic [CFG_W-1:0] raw, input int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // Work out the scatter result of one voxel and step the raster position
    function automatic t_scatter predict_scatter(input logic [VALUE_W-1:0] value);
        int unsigned n, nch, m, a, b, c, nb, nc, dest;
        logic [2:0]  face;
        logic [1:0]  turn;
        logic        last_k, last_j, last_i, last_c;
        t_scatter    r;
        n    = effective_limit(model_side, SIDE_LIMIT);
        nch  = effective_limit(model_channels, CHANNEL_LIMIT);
        m    = n - 1;
        face = 3'(model_rotation % NUM_FACES);
        turn = 2'((model_rotation / NUM_FACES) % NUM_TURNS);
        a = walk_i;
        b = walk_j;
        c = walk_k;
        // Turn the cube onto the chosen face
        case (face)
            FACE_J_TO_I: begin
                a = walk_j; b = m - walk_i; c = walk_k;
            end
            FACE_FLIP_IJ: begin
                a = m - walk_i; b = m - walk_j; c = walk_k;
            end
            FACE_MJ_TO_I: begin
                a = m - walk_j; b = walk_i; c = walk_k;
            end
            FACE_K_TO_I: begin
                a = walk_k; b = walk_j; c = m - walk_i;
            end
            FACE_MK_TO_I: begin
                a = m - walk_k; b = walk_j; c = walk_i;
            end
            default: ;
        endcase
        // Quarter turn about the i axis
        nb = b;
        nc = c;
        case (turn)
            TURN_90: begin
                nb = c; nc = m - b;
            end
            TURN_180: begin
                nb = m - b; nc = m - c;
            end
            TURN_270: begin
                nb = m - c; nc = b;
            end
            default: ;
        endcase
        dest   = walk_chan * (n * n * n) + (a * n + nb) * n + nc;
        last_k = walk_k >= m;
        last_j = walk_j >= m;
        last_i = walk_i >= m;
        last_c = walk_chan >= nch - 1;
        r.value = value;
        r.dest  = DEST_W'(dest);
        r.done  = last_k && last_j && last_i && last_c;
        // Advance the raster position, k fastest
        if (!last_k) begin
            walk_k++;
        end else begin
            walk_k = 0;
            if (!last_j) begin
                walk_j++;
            end else begin
                walk_j = 0;
                if (!last_i) begin
                    walk_i++;
                end else begin
                    walk_i    = 0;
                    walk_chan = last_c ? 0 : walk_chan + 1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Offer one voxel request, idle at random first, hold it until taken
    task automatic send_voxel(input logic [VALUE_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_voxel_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_scatter.insert(pending_scatter.size(), predict_scatter(value));
        voxels_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_scatter.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_CUBE_SIDE:     model_side     = data;
            REG_CHANNEL_COUNT: model_channels = data;
            REG_ROTATION:      model_rotation = data[ROT_W-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] side, input logic [CFG_W-1:0] chans,
                             input logic [ROT_W-1:0] rot);
        write_register(REG_CUBE_SIDE, side);
        write_register(REG_CHANNEL_COUNT, chans);
        write_register(REG_ROTATION, CFG_W'(rot));
    endtask

    // Drive the result ready, stalling at random
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_scatter exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scatter.size() == 0) begin
                report_mismatch($sformatf("result value %h dest %0d with nothing expected",
                                          o_voxel_value_out, o_dest_index));
            end else begin
                exp_r = pending_scatter.pop_front();
                if (o_voxel_value_out !== exp_r.value)
                    report_mismatch($sformatf("voxel value %h, expected %h",
                                              o_voxel_value_out, exp_r.value));
                if (o_dest_index !== exp_r.dest)
                    report_mismatch($sformatf("dest index %0d, expected %0d",
                                              o_dest_index, exp_r.dest));
                if (o_example_done !== exp_r.done)
                    report_mismatch($sformatf("example done %b, expected %b",
                                              o_example_done, exp_r.done));
                if (exp_r.done) examples_seen++;
            end
        end
    end

    // Register defaults after reset: identity, side 32, one channel
    task automatic test_reset_defaults();
        send_voxel('0);
        send_voxel('1);
        repeat (6) send_voxel($urandom());
        drain_results();
    endtask

    // Zero and out-of-range sizes, rotation codes past 23
    task automatic test_register_limits();
        configure(7'd0, 7'd0, 5'd0);
        send_voxel('0);
        send_voxel('1);
        send_voxel(32'h5555_aaaa);
        drain_results();
        configure(7'd127, 7'd127, 5'd31);
        send_voxel(32'haaaa_5555);
        send_voxel($urandom());
        drain_results();
        configure(7'd64, 7'd64, 5'd24);
        send_voxel($urandom());
        send_voxel($urandom());
        drain_results();
    endtask

    // Step through the 24 orientations on a 2-cube
    task automatic test_orientations();
        configure(7'd2, 7'd1, 5'd0);
        for (int rot = 0; rot < 24; rot++) begin
            write_register(REG_ROTATION, CFG_W'(rot));
            send_voxel($urandom());
            drain_results();
        end
    endtask

    // Park the channel counter high, then grow and shrink the cube under it
    task automatic test_deep_index();
        configure(7'd1, 7'd64, 5'd0);
        repeat (63) send_voxel($urandom());
        drain_results();
        configure(7'd64, 7'd2, 5'd2);
        repeat (4) send_voxel($urandom());
        drain_results();
        write_register(REG_CUBE_SIDE, 7'd2);
        write_register(REG_ROTATION, 7'd5);
        repeat (8) send_voxel($urandom());
        drain_results();
    endtask

    // Random configurations with random bursts, often ending on an example boundary
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int          sent;
        int          sel;
        int          len;
        int unsigned n, nch, remaining;
        logic [CFG_W-1:0] side, chans;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)      side = CFG_W'($urandom_range(1, 4));
            else if (sel < 85) side = CFG_W'($urandom_range(5, 8));
            else if (sel < 92) side = '0;
            else               side = CFG_W'($urandom_range(64, 127));
            sel = $urandom_range(0, 99);
            if (sel < 70)      chans = CFG_W'($urandom_range(1, 3));
            else if (sel < 85) chans = CFG_W'($urandom_range(4, 8));
            else if (sel < 92) chans = '0;
            else               chans = CFG_W'($urandom_range(64, 127));
            if ($urandom_range(0, 9) < 7) write_register(REG_CUBE_SIDE, side);
            if ($urandom_range(0, 9) < 7) write_register(REG_CHANNEL_COUNT, chans);
            if ($urandom_range(0, 9) < 7)
                write_register(REG_ROTATION, CFG_W'($urandom_range(0, 31)));
            n   = effective_limit(model_side, SIDE_LIMIT);
            nch = effective_limit(model_channels, CHANNEL_LIMIT);
            len = (n > 8) ? $urandom_range(1, 6) : $urandom_range(8, 48);
            // Finish the current example when it is close
            if (walk_i < n && walk_j < n && walk_k < n && walk_chan < nch &&
                    $urandom_range(0, 1) == 1) begin
                remaining = (nch - 1 - walk_chan) * n * n * n + (n - 1 - walk_i) * n * n
                          + (n - 1 - walk_j) * n + (n - 1 - walk_k) + 1;
                if (remaining <= 200) len = remaining;
            end
            repeat (len) send_voxel($urandom());
            sent += len;
            drain_results();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_limits();
        test_orientations();
        test_deep_index();
        test_random_traffic(20, 77);
        test_random_traffic(77, 20);
        test_random_traffic(0, 0);

        drain_results();
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (pending_scatter.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_scatter.size()));

        $display("Sent %0d voxels over %0d register writes; %0d examples completed.",
                 voxels_sent, config_writes, examples_seen);
        $display("Covered all 32 rotation codes, clamped sizes and mid-example changes.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("Timeout: %0d results still expected", pending_scatter.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== voxel_cube_rotation_scatter.f =====
+incdir+rtl
rtl/vcr_pkg.sv
rtl/vcr_front.sv
rtl/vcr_queue.sv
rtl/vcr_back.sv
rtl/voxel_cube_rotation_scatter.sv
rtl/vcr_checker.sv
tb/sv/voxel_cube_rotation_scatter_test.sv
